[src/mmh_pkg.sv]
`timescale 1ns / 1ps
// Shared definitions for the min-max heap block.
// Used by the heap engine and the top level.
package mmh_pkg;
  localparam int unsigned CAPACITY = 1024;
  localparam int unsigned KEY_W = 32;
  localparam logic [1:0] MODE_INSERT = 2'd0;
  localparam logic [1:0] MODE_DEL_MIN = 2'd1;
  localparam logic [1:0] MODE_DEL_MAX = 2'd2;
  localparam logic [1:0] MODE_UNUSED = 2'd3;

  typedef struct packed {
    logic signed [KEY_W-1:0] removed_key;
    logic removed_valid;
    logic fault;
    logic signed [KEY_W-1:0] current_min;
    logic signed [KEY_W-1:0] current_max;
  } mmh_result_t;
endpackage

[src/mmh_ram.sv]
`timescale 1ns / 1ps
// Generic single-port synchronous RAM with a registered read.
// No dependencies.
module mmh_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

[src/mmh_engine.sv]
`timescale 1ns / 1ps
// Heap engine: a sequencer that sifts keys up and down through the heap RAM.
// Depends on mmh_pkg and mmh_ram.
module mmh_engine #(
  parameter int unsigned CAPACITY = mmh_pkg::CAPACITY,
  localparam int unsigned AW = $clog2(CAPACITY),
  localparam int unsigned CW = $clog2(CAPACITY + 1)
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     start,
  input  logic [1:0]               mode,
  input  logic signed [31:0]       key,
  output logic                     busy,
  output logic                     done,
  output mmh_pkg::mmh_result_t     res,
  output logic [CW-1:0]            count
);
  typedef enum logic [4:0] {
    S_IDLE, S_UP_RD, S_UP_CMP, S_UP_WR, S_RM_RD, S_RM_LAST, S_RM_SEL,
    S_TD_INIT, S_TD_RD, S_TD_CMP, S_TD_PRD, S_TD_PCMP, S_TD_WR, S_TD_WR2,
    S_ST_RD, S_ST_W1, S_ST_W2, S_FIN
  } state_t;

  state_t state;
  logic we;
  logic [AW-1:0] addr;
  logic signed [31:0] wdata, rdata;

  mmh_ram #(.WIDTH(32), .DEPTH(CAPACITY)) u_ram (
    .clk(clk), .we(we), .addr(addr), .wdata(wdata), .rdata(rdata)
  );

  logic [CW-1:0] n;
  logic want_max;
  logic signed [31:0] cur;
  logic [CW+1:0] pos;
  logic [CW+1:0] tgt;
  logic signed [31:0] tval;
  logic [CW+1:0] best;
  logic signed [31:0] bval;
  logic bfound;
  logic [2:0] k;
  logic [CW+1:0] par;
  logic [1:0] sk;
  logic signed [31:0] s2, s1, s0;

  function automatic logic better(input logic mx, input logic signed [31:0] a,
                                  input logic signed [31:0] b);
    return mx ? (a > b) : (a < b);
  endfunction

  function automatic logic odd_level(input logic [CW+1:0] i);
    logic [CW+2:0] v;
    logic p;
    v = {1'b0, i} + 1'b1;
    p = 1'b0;
    for (int b = 1; b <= CW + 2; b++) begin
      if (v[b]) begin
        p = b[0];
      end
    end
    return p;
  endfunction

  logic [CW+1:0] cand;
  always_comb begin
    if (k < 3'd4) begin
      cand = (CW+2)'((pos << 2) + 3 + k);
    end else begin
      cand = (CW+2)'((pos << 1) + 1 + (k - 3'd4));
    end
  end

  always_comb begin
    we = 1'b0;
    addr = AW'(pos);
    wdata = cur;
    case (state)
      S_UP_RD: addr = AW'(tgt);
      S_UP_WR: begin
        we = 1'b1;
        addr = AW'(pos);
        wdata = tval;
      end
      S_RM_SEL: addr = AW'(sk);
      S_RM_RD: addr = AW'(tgt);
      S_RM_LAST: addr = AW'(n);
      S_TD_RD: addr = AW'(cand);
      S_TD_PRD: addr = AW'(par);
      S_TD_WR: begin
        we = 1'b1;
        addr = AW'(pos);
        wdata = bval;
      end
      S_TD_WR2: begin
        we = 1'b1;
        addr = AW'(pos);
        wdata = tval;
      end
      S_ST_RD: addr = AW'(sk);
      S_ST_W1: addr = AW'(sk);
      S_FIN: begin
        we = 1'b1;
        addr = AW'(pos);
        wdata = cur;
      end
      default: addr = AW'(pos);
    endcase
  end

  assign busy = (state != S_IDLE);
  assign count = n;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      n <= '0;
      done <= 1'b0;
    end else begin
      done <= (state == S_ST_W2);
      case (state)
        S_IDLE: begin
          if (start) begin
            cur <= key;
            res.removed_key <= '0;
            res.current_min <= '0;
            res.current_max <= '0;
            res.fault <= (mode == mmh_pkg::MODE_INSERT) ? (n >= CW'(CAPACITY)) :
                         ((mode == mmh_pkg::MODE_DEL_MIN ||
                           mode == mmh_pkg::MODE_DEL_MAX) && (n == '0));
            res.removed_valid <= (mode == mmh_pkg::MODE_DEL_MIN ||
                                  mode == mmh_pkg::MODE_DEL_MAX) && (n != '0);
            if (mode == mmh_pkg::MODE_INSERT) begin
              if (n >= CW'(CAPACITY)) begin
                state <= S_ST_RD;
                sk <= 2'd0;
              end else begin
                pos <= (CW+2)'(n);
                n <= n + 1'b1;
                if (n == '0) begin
                  state <= S_FIN;
                end else begin
                  tgt <= (CW+2)'(((CW+2)'(n) - 1) >> 1);
                  want_max <= ~odd_level((CW+2)'(n));
                  k <= 3'd0;
                  state <= S_UP_RD;
                end
              end
            end else if (mode == mmh_pkg::MODE_DEL_MIN ||
                         mode == mmh_pkg::MODE_DEL_MAX) begin
              if (n == '0) begin
                state <= S_ST_RD;
                sk <= 2'd0;
              end else begin
                want_max <= (mode == mmh_pkg::MODE_DEL_MAX);
                if (mode == mmh_pkg::MODE_DEL_MIN || n == CW'(1)) begin
                  tgt <= '0;
                  state <= S_RM_RD;
                end else if (n == CW'(2)) begin
                  tgt <= (CW+2)'(1);
                  state <= S_RM_RD;
                end else begin
                  sk <= 2'd1;
                  state <= S_RM_SEL;
                end
                k <= 3'd0;
              end
            end else begin
              state <= S_ST_RD;
              sk <= 2'd0;
            end
          end
        end
        // Insert: k=0 compares with the parent, later steps with grandparents.
        S_UP_RD: state <= S_UP_CMP;
        S_UP_CMP: begin
          if (k == 3'd0) begin
            k <= 3'd1;
            tval <= rdata;
            if (better(want_max, cur, rdata)) begin
              state <= S_UP_WR;
            end else begin
              if (pos >= 3) begin
                tgt <= (CW+2)'((pos - 3) >> 2);
                state <= S_UP_RD;
              end else begin
                state <= S_FIN;
              end
              want_max <= ~want_max;
            end
          end else begin
            tval <= rdata;
            if (better(want_max, cur, rdata)) begin
              state <= S_UP_WR;
            end else begin
              state <= S_FIN;
            end
          end
        end
        S_UP_WR: begin
          pos <= tgt;
          if (tgt >= 3) begin
            tgt <= (CW+2)'((tgt - 3) >> 2);
            state <= S_UP_RD;
          end else begin
            state <= S_FIN;
          end
        end
        S_RM_SEL: begin
          if (sk == 2'd1) begin
            sk <= 2'd2;
          end else if (sk == 2'd2) begin
            s1 <= rdata;
            sk <= 2'd3;
          end else begin
            tgt <= (s1 > rdata) ? (CW+2)'(1) : (CW+2)'(2);
            state <= S_RM_RD;
          end
        end
        S_RM_RD: begin
          pos <= tgt;
          state <= S_RM_LAST;
          n <= n - 1'b1;
        end
        S_RM_LAST: begin
          res.removed_key <= rdata;
          if (pos < (CW+2)'(n)) begin
            state <= S_TD_INIT;
          end else begin
            state <= S_ST_RD;
            sk <= 2'd0;
          end
        end
        S_TD_INIT: begin
          cur <= rdata;
          k <= 3'd0;
          bfound <= 1'b0;
          if (((pos << 1) + 1) >= (CW+2)'(n)) begin
            state <= S_FIN;
          end else begin
            state <= S_TD_RD;
          end
        end
        S_TD_RD: begin
          if (cand >= (CW+2)'(n)) begin
            if (k == 3'd5) begin
              state <= S_TD_CMP;
              k <= 3'd6;
            end else begin
              k <= k + 1'b1;
            end
          end else begin
            tgt <= cand;
            state <= S_TD_CMP;
          end
        end
        S_TD_CMP: begin
          if (k != 3'd6) begin
            if (!bfound || better(want_max, rdata, bval)) begin
              best <= tgt;
              bval <= rdata;
              bfound <= 1'b1;
            end
            if (k == 3'd5) begin
              k <= 3'd6;
            end else begin
              k <= k + 1'b1;
              state <= S_TD_RD;
            end
          end else begin
            if (!better(want_max, bval, cur)) begin
              state <= S_FIN;
            end else if (best >= (pos << 2) + 3) begin
              par <= (CW+2)'((best - 1) >> 1);
              state <= S_TD_WR;
            end else begin
              state <= S_TD_WR;
              par <= '0;
            end
          end
        end
        S_TD_WR: begin
          if (best >= (pos << 2) + 3) begin
            pos <= best;
            state <= S_TD_PRD;
          end else begin
            pos <= best;
            state <= S_FIN;
          end
        end
        S_TD_PRD: state <= S_TD_PCMP;
        S_TD_PCMP: begin
          if (better(want_max, rdata, cur)) begin
            cur <= rdata;
            tval <= cur;
            pos <= par;
            best <= pos;
            state <= S_TD_WR2;
          end else begin
            k <= 3'd0;
            bfound <= 1'b0;
            if (((pos << 1) + 1) >= (CW+2)'(n)) state <= S_FIN;
            else state <= S_TD_RD;
          end
        end
        S_TD_WR2: begin
          pos <= best;
          k <= 3'd0;
          bfound <= 1'b0;
          if (((best << 1) + 1) >= (CW+2)'(n)) state <= S_FIN;
          else state <= S_TD_RD;
        end
        S_FIN: begin
          sk <= 2'd0;
          state <= S_ST_RD;
        end
        S_ST_RD: begin
          state <= S_ST_W1;
          sk <= sk + 1'b1;
        end
        S_ST_W1: begin
          if (sk == 2'd1) s0 <= rdata;
          else if (sk == 2'd2) s1 <= rdata;
          else s2 <= rdata;
          if (sk == 2'd3) begin
            state <= S_ST_W2;
          end else begin
            sk <= sk + 1'b1;
          end
        end
        S_ST_W2: begin
          if (n != '0) res.current_min <= s0;
          if (n == CW'(1)) res.current_max <= s0;
          else if (n == CW'(2)) res.current_max <= s1;
          else if (n != '0) res.current_max <= (s1 > s2) ? s1 : s2;
          state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end
endmodule

[src/min_max_heap_top.sv]
`timescale 1ns / 1ps
// Min-max heap top level: stream ports around the heap engine.
// Depends on mmh_pkg and mmh_engine.
// One item is taken at a time, and s_tready stays low until the result transfer of
// the previous item has completed. A delete walks down two heap levels per step, an
// insert climbs to the parent and then two levels per step, and every item also
// passes through setup, status reads and output hand-off; each step is bound by the
// single port of the heap RAM.
module min_max_heap_top #(
  parameter int unsigned CAPACITY = mmh_pkg::CAPACITY
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_tvalid,
  output logic         s_tready,
  input  logic [39:0]  s_tdata,   // mode[1:0], key[33:2], zero fill
  output logic         m_tvalid,
  input  logic         m_tready,
  output logic [111:0] m_tdata    // removed_key, removed_valid, fault,
                                  // current_min, current_max, entry_count
);
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  logic busy, done;
  mmh_pkg::mmh_result_t res;
  logic [CW-1:0] count;

  assign s_tready = ~busy & ~m_tvalid & ~done;

  mmh_engine #(.CAPACITY(CAPACITY)) u_engine (
    .clk(clk), .rst(rst), .start(s_tvalid & s_tready),
    .mode(s_tdata[1:0]), .key(s_tdata[33:2]),
    .busy(busy), .done(done), .res(res), .count(count)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else begin
      if (done) begin
        m_tvalid <= 1'b1;
        m_tdata <= {3'b0, 11'(count), res.current_max, res.current_min, res.fault,
                    res.removed_valid, res.removed_key};
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end
endmodule

[src/min_max_heap_checker.sv]
`timescale 1ns / 1ps
// Port checker for the min-max heap top level.
// Bound to min_max_heap_top.
module min_max_heap_checker (
  input logic clk,
  input logic rst,
  input logic s_tvalid,
  input logic s_tready,
  input logic m_tvalid,
  input logic m_tready,
  input logic [111:0] m_tdata
);
  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata)) else $error("hold");
  a_one: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !s_tready) else $error("overlap");
  a_busy: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> !s_tready) else $error("busy");
  a_flags: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> !(m_tdata[32] && m_tdata[33])) else $error("flags");
  a_empty: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[108:98] == 11'd0 |-> m_tdata[97:34] == 64'd0)
    else $error("empty");
endmodule

bind min_max_heap_top min_max_heap_checker u_checker (
  .clk(clk), .rst(rst), .s_tvalid(s_tvalid), .s_tready(s_tready),
  .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
);
